### rtl/itoa_pkg.sv
// Package: formats, state encoding, command/status types and character lookup.
package itoa_pkg;

    localparam int VALUE_W   = 64;
    localparam int OP_W      = 2;
    localparam int CHAR_W    = 7;
    localparam int COUNT_W   = 32;
    localparam int NDIG_W    = 5;
    localparam int BIN_W     = 32;
    localparam int BCD_W     = 40;
    localparam int DABBLE_W  = 5;
    localparam int M_DATA_W  = 40;

    localparam logic [OP_W-1:0] OP_DEC       = 2'd0;
    localparam logic [OP_W-1:0] OP_HEX_LOWER = 2'd1;
    localparam logic [OP_W-1:0] OP_HEX_UPPER = 2'd2;
    localparam logic [OP_W-1:0] OP_HEX64     = 2'd3;

    localparam logic [NDIG_W-1:0] NDIG_DEC   = 5'd10;
    localparam logic [NDIG_W-1:0] NDIG_HEX32 = 5'd8;
    localparam logic [NDIG_W-1:0] NDIG_HEX64 = 5'd16;

    localparam logic [DABBLE_W-1:0] DABBLE_LAST = 5'd31;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_UA_OFS = 7'd55;
    localparam logic [CHAR_W-1:0] CHAR_LA_OFS = 7'd87;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic dabble;
        logic skip;
        logic shift;
        logic count;
        logic sel_sign;
    } itoa_cmd_t;

    typedef struct packed {
        logic dabble_done;
        logic skip_done;
        logic is_last;
        logic neg;
    } itoa_status_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [CHAR_W-1:0] n;
        n = {3'b000, nib};
        if (nib < 4'd10) begin
            hex_char = CHAR_ZERO + n;
        end else if (upper) begin
            hex_char = CHAR_UA_OFS + n;
        end else begin
            hex_char = CHAR_LA_OFS + n;
        end
    endfunction

endpackage

### rtl/itoa_ctrl.sv
// Controller: sequences load, binary-to-BCD conversion, zero skip and character output.
module itoa_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic [itoa_pkg::OP_W-1:0]  op,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic                       m_tlast,
    output itoa_pkg::itoa_cmd_t        cmd,
    input  itoa_pkg::itoa_status_t     status
);
    import itoa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        m_tlast    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = (op == OP_DEC) ? ST_CONVERT : ST_SKIP;
                end
            end
            ST_CONVERT: begin
                cmd.dabble = 1'b1;
                if (status.dabble_done) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (status.skip_done) begin
                    state_next = status.neg ? ST_SIGN : ST_EMIT;
                end else begin
                    cmd.skip = 1'b1;
                end
            end
            ST_SIGN: begin
                m_tvalid     = 1'b1;
                cmd.sel_sign = 1'b1;
                if (m_tready) begin
                    cmd.count  = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                m_tlast  = status.is_last;
                if (m_tready) begin
                    cmd.count = 1'b1;
                    cmd.shift = 1'b1;
                    if (status.is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a character is pending");

    a_convert_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONVERT && status.dabble_done) |=> (state_reg == ST_SKIP))
        else $error("conversion did not hand over to zero skip");

    a_sign_then_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SIGN && m_tready) |=> (state_reg == ST_EMIT && !status.neg == 1'b0))
        else $error("sign transfer not followed by digits");

endmodule

### rtl/itoa_datapath.sv
// Datapath: digit register, double-dabble conversion, character lookup and running count.
module itoa_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [itoa_pkg::OP_W-1:0]     op,
    input  logic [itoa_pkg::VALUE_W-1:0]  value,
    input  itoa_pkg::itoa_cmd_t           cmd,
    output itoa_pkg::itoa_status_t        status,
    output logic [itoa_pkg::CHAR_W-1:0]   char_code,
    output logic [itoa_pkg::COUNT_W-1:0]  emitted_total
);
    import itoa_pkg::*;

    logic [VALUE_W-1:0]  digits_reg, digits_next;
    logic [BIN_W-1:0]    bin_reg, bin_next;
    logic [NDIG_W-1:0]   ndig_reg, ndig_next;
    logic [DABBLE_W-1:0] dab_reg, dab_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                neg_reg, neg_next;
    logic                upper_reg, upper_next;
    logic [BCD_W-1:0]    bcd_adj;
    logic [BIN_W-1:0]    low;
    logic [3:0]          top_nib;

    assign low     = value[BIN_W-1:0];
    assign top_nib = digits_reg[VALUE_W-1 -: 4];

    always_comb begin
        for (int i = 0; i < BCD_W / 4; i++) begin
            if (digits_reg[VALUE_W-BCD_W + 4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = digits_reg[VALUE_W-BCD_W + 4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = digits_reg[VALUE_W-BCD_W + 4*i +: 4];
            end
        end
    end

    always_comb begin
        digits_next = digits_reg;
        bin_next    = bin_reg;
        ndig_next   = ndig_reg;
        dab_next    = dab_reg;
        neg_next    = neg_reg;
        upper_next  = upper_reg;
        count_next  = count_reg;
        if (cmd.load) begin
            dab_next   = '0;
            upper_next = (op == OP_HEX_UPPER);
            neg_next   = 1'b0;
            bin_next   = low;
            case (op)
                OP_DEC: begin
                    neg_next    = low[BIN_W-1];
                    bin_next    = low[BIN_W-1] ? (BIN_W'(0) - low) : low;
                    digits_next = '0;
                    ndig_next   = NDIG_DEC;
                end
                OP_HEX64: begin
                    digits_next = value;
                    ndig_next   = NDIG_HEX64;
                end
                default: begin
                    digits_next = {low, {(VALUE_W-BIN_W){1'b0}}};
                    ndig_next   = NDIG_HEX32;
                end
            endcase
        end
        if (cmd.dabble) begin
            digits_next = {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1], {(VALUE_W-BCD_W){1'b0}}};
            bin_next    = {bin_reg[BIN_W-2:0], 1'b0};
            dab_next    = dab_reg + 1'b1;
        end
        if (cmd.skip || cmd.shift) begin
            digits_next = {digits_reg[VALUE_W-5:0], 4'h0};
            ndig_next   = ndig_reg - 1'b1;
        end
        if (cmd.count) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            dab_reg   <= '0;
        end else begin
            count_reg <= count_next;
            dab_reg   <= dab_next;
        end
    end

    always_ff @(posedge aclk) begin
        digits_reg <= digits_next;
        bin_reg    <= bin_next;
        ndig_reg   <= ndig_next;
        neg_reg    <= neg_next;
        upper_reg  <= upper_next;
    end

    assign status.dabble_done = (dab_reg == DABBLE_LAST);
    assign status.is_last     = (ndig_reg == NDIG_W'(1));
    assign status.skip_done   = (ndig_reg == NDIG_W'(1)) || (top_nib != 4'h0);
    assign status.neg         = neg_reg;

    assign char_code     = cmd.sel_sign ? CHAR_MINUS : hex_char(top_nib, upper_reg);
    assign emitted_total = count_reg + 1'b1;

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.count |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("character count did not advance on transfer");

    a_digits_left: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift |-> (ndig_reg != '0))
        else $error("digit emitted with no digits left");

endmodule

### rtl/integer_to_ascii_digits_unit.sv
// Top level: integer to ASCII decimal/hex character stream.
// Sequence: hex formats skip leading zero digits, one per cycle, after the input transfer;
// decimal first converts the 32 low input bits by shift-and-add-3, one input bit per cycle.
// Output: one character per cycle while m_tready is high; a new input is accepted only
// after the last character of the current item has been transferred.
// Reset: aresetn synchronous active low; clears the controller, the conversion step counter and the character count.
module integer_to_ascii_digits_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [itoa_pkg::VALUE_W-1:0]    s_tdata,   // [63:0] value
    input  logic [itoa_pkg::OP_W-1:0]       s_tuser,   // [1:0] op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [itoa_pkg::M_DATA_W-1:0]   m_tdata,   // [6:0] char_code, [38:7] emitted_total
    output logic                            m_tlast    // last
);
    import itoa_pkg::*;

    itoa_cmd_t           cmd;
    itoa_status_t        status;
    logic [CHAR_W-1:0]   char_code;
    logic [COUNT_W-1:0]  emitted_total;

    itoa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

    itoa_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .op            (s_tuser),
        .value         (s_tdata),
        .cmd           (cmd),
        .status        (status),
        .char_code     (char_code),
        .emitted_total (emitted_total)
    );

    assign m_tdata = {1'b0, emitted_total, char_code};

endmodule

### verif/integer_to_ascii_digits_unit_tb.sv
// Testbench for integer_to_ascii_digits_unit: random and directed numbers checked per character.
`timescale 1ns / 100ps

module integer_to_ascii_digits_unit_tb;

    import itoa_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          N_RANDOM    = 340;
    localparam int          HOLD_AFTER  = 30;
    localparam int          HOLD_CYCLES = 400;
    localparam int          SETTLE      = 80;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        int unsigned        gap;
        bit                 drain;
    } number_t;

    typedef struct {
        logic [CHAR_W-1:0]  code;
        logic               last;
        logic [COUNT_W-1:0] total;
    } char_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [VALUE_W-1:0]    s_tdata  = '0;
    logic [OP_W-1:0]       s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;

    number_t            number_q[$];
    char_t              char_q[$];
    logic [COUNT_W-1:0] emitted_count = '0;
    int                 n_numbers     = 0;
    int                 n_accepted    = 0;
    int                 n_errors      = 0;
    int unsigned        cycle_cnt     = 0;
    int unsigned        hold_cnt      = 0;
    bit                 hold_done     = 1'b0;

    integer_to_ascii_digits_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void push_char(input logic [CHAR_W-1:0] code, input logic last);
        char_t c;
        emitted_count = emitted_count + 1'b1;
        c.code  = code;
        c.last  = last;
        c.total = emitted_count;
        char_q.push_back(c);
    endfunction

    // Expand one number into the characters it must produce.
    function automatic void predict_chars(input logic [OP_W-1:0] op,
                                          input logic [VALUE_W-1:0] value);
        logic [7:0]  digs [16];
        int          nd;
        logic        neg;
        logic [31:0] mag32;
        logic [63:0] mag64;
        string       digit_set;
        nd  = 0;
        neg = 1'b0;
        if (op == OP_DEC) begin
            mag32 = value[31:0];
            if (mag32[31]) begin
                neg   = 1'b1;
                mag32 = -mag32;
            end
            do begin
                digs[nd] = 8'd48 + 8'(mag32 % 32'd10);
                nd++;
                mag32 = mag32 / 32'd10;
            end while (mag32 != 0);
        end else begin
            digit_set = (op == OP_HEX_UPPER) ? "0123456789ABCDEF" : "0123456789abcdef";
            mag64     = (op == OP_HEX64) ? value : {32'd0, value[31:0]};
            do begin
                digs[nd] = digit_set[int'(mag64[3:0])];
                nd++;
                mag64 = mag64 >> 4;
            end while (mag64 != 0 && nd < 16);
        end
        if (neg) begin
            push_char(CHAR_MINUS, 1'b0);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            push_char(digs[i][CHAR_W-1:0], i == 0);
        end
    endfunction

    function automatic void add_number(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                                       input int unsigned gap, input bit drain);
        number_t n;
        n.op    = op;
        n.value = value;
        n.gap   = gap;
        n.drain = drain;
        number_q.push_back(n);
        n_numbers++;
    endfunction

    // Driver: offer queued numbers, predict on each transfer.
    number_t     tx_cur;
    bit          tx_armed = 1'b0;
    bit          tx_on    = 1'b0;
    int unsigned tx_wait  = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_on    = 1'b0;
            tx_armed = 1'b0;
        end else begin
            if (tx_on && s_tready) begin
                predict_chars(tx_cur.op, tx_cur.value);
                n_accepted <= n_accepted + 1;
                tx_on    = 1'b0;
                tx_armed = 1'b0;
            end
            if (!tx_on) begin
                if (!tx_armed && number_q.size() > 0) begin
                    tx_cur   = number_q.pop_front();
                    tx_wait  = tx_cur.gap;
                    tx_armed = 1'b1;
                end
                if (tx_armed) begin
                    if (tx_cur.drain && char_q.size() != 0) begin
                        tx_on = 1'b0;
                    end else if (tx_wait != 0) begin
                        tx_wait--;
                    end else begin
                        tx_on = 1'b1;
                    end
                end
            end
            s_tvalid <= tx_on;
            if (tx_on) begin
                s_tdata <= tx_cur.value;
                s_tuser <= tx_cur.op;
            end
        end
    end

    // Long receiver hold-off once HOLD_AFTER numbers have been accepted.
    always @(posedge aclk) begin
        if (!hold_done && n_accepted == HOLD_AFTER) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Monitor: check each character transfer against the oldest expectation.
    int unsigned rx_wait = 0;
    bit          rx_rdy;
    char_t       want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = $urandom_range(0, 19);
        end else begin
            if (m_tvalid && m_tready) begin
                if (char_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("unexpected character: code %0d last %0b total %0d",
                                 m_tdata[6:0], m_tlast, m_tdata[38:7]);
                    end
                end else begin
                    want = char_q.pop_front();
                    if (m_tdata[6:0] !== want.code || m_tlast !== want.last ||
                        m_tdata[38:7] !== want.total) begin
                        n_errors++;
                        if (n_errors <= 10) begin
                            $display("mismatch: expected code %0d last %0b total %0d, got %0d %0b %0d",
                                     want.code, want.last, want.total,
                                     m_tdata[6:0], m_tlast, m_tdata[38:7]);
                        end
                    end
                end
                rx_wait = (cycle_cnt[11:10] == 2'b00) ? 0 : $urandom_range(0, 19);
            end
            if (hold_cnt != 0) begin
                rx_rdy = 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait--;
                rx_rdy = 1'b0;
            end else begin
                rx_rdy = 1'b1;
            end
            m_tready <= rx_rdy;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("integer_to_ascii_digits_unit_tb: done, errors");
            $finish;
        end
    end

    initial begin
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] v;
        int unsigned        gap;

        add_number(OP_DEC, 64'd0, 0, 1'b0);
        add_number(OP_DEC, 64'd1, 3, 1'b0);
        add_number(OP_DEC, 64'h0000_0000_ffff_ffff, 0, 1'b0);
        add_number(OP_DEC, 64'h0000_0000_7fff_ffff, 1, 1'b0);
        add_number(OP_DEC, 64'h0000_0000_8000_0000, 0, 1'b0);
        add_number(OP_DEC, 64'd10, 5, 1'b0);
        add_number(OP_DEC, 64'd1000000000, 0, 1'b0);
        add_number(OP_DEC, 64'hdead_beef_0000_0009, 0, 1'b0);
        add_number(OP_DEC, 64'hffff_ffff_8000_0001, 2, 1'b0);
        add_number(OP_HEX_LOWER, 64'd0, 0, 1'b0);
        add_number(OP_HEX_LOWER, 64'h0000_0000_ffff_ffff, 0, 1'b0);
        add_number(OP_HEX_LOWER, 64'hffff_ffff_abcd_ef01, 4, 1'b0);
        add_number(OP_HEX_LOWER, 64'h0000_0000_0000_000f, 0, 1'b0);
        add_number(OP_HEX_UPPER, 64'd0, 0, 1'b0);
        add_number(OP_HEX_UPPER, 64'h1234_5678_abcd_ef12, 0, 1'b1);
        add_number(OP_HEX_UPPER, 64'h0000_0000_8000_0000, 7, 1'b0);
        add_number(OP_HEX_UPPER, 64'h0000_0000_ffff_ffff, 0, 1'b0);
        add_number(OP_HEX64, 64'd0, 0, 1'b0);
        add_number(OP_HEX64, 64'hffff_ffff_ffff_ffff, 0, 1'b0);
        add_number(OP_HEX64, 64'h8000_0000_0000_0000, 2, 1'b0);
        add_number(OP_HEX64, 64'd1, 0, 1'b0);
        add_number(OP_HEX64, 64'h0123_4567_89ab_cdef, 0, 1'b0);

        for (int i = 0; i < N_RANDOM; i++) begin
            op = OP_W'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0: begin
                    v = {$urandom, $urandom};
                end
                1: begin
                    v = {$urandom, $urandom} >> $urandom_range(0, 63);
                end
                2: begin
                    v = {$urandom, 32'd0 - 32'($urandom_range(0, 5000))};
                end
                3: begin
                    v = VALUE_W'($urandom_range(0, 20));
                end
                default: begin
                    v = {$urandom, $urandom} >> $urandom_range(28, 60);
                end
            endcase
            gap = ((i / 40) % 3 == 1) ? 0 : $urandom_range(0, 19);
            add_number(op, v, gap, (i % 97) == 50);
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_accepted != n_numbers || char_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);

        if (char_q.size() != 0) begin
            $display("%0d expected characters never arrived", char_q.size());
        end
        if (n_errors == 0 && char_q.size() == 0) begin
            $display("integer_to_ascii_digits_unit_tb: done, clean");
        end else begin
            $display("integer_to_ascii_digits_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

### files.f
rtl/itoa_pkg.sv
rtl/itoa_ctrl.sv
rtl/itoa_datapath.sv
rtl/integer_to_ascii_digits_unit.sv
verif/integer_to_ascii_digits_unit_tb.sv
